// File: hw/rtl/rpn_pkg.sv
// Shared types and constants for the relative path normaliser.
// No dependencies; used by every module of the block.
package rpn_pkg;

  // Status codes carried on the closing item of a path
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PREFIX  = 3'd1;
  localparam logic [2:0] ST_BADCHAR = 3'd2;
  localparam logic [2:0] ST_LEADING = 3'd3;
  localparam logic [2:0] ST_PARENT  = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // Segment phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DOT1  = 2'd1;
  localparam logic [1:0] PH_DOT2  = 2'd2;
  localparam logic [1:0] PH_SEG   = 2'd3;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LOW   = 8'h20;

  // "content/" with the first byte in the top bits
  localparam logic [63:0] CONTENT_SLASH = 64'h636F_6E74_656E_742F;
  localparam int unsigned PREFIX_DEPTH = 8;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Command per byte that gives output or ends a path: separator, pending dots, byte, status
  typedef struct packed {
    logic       sep;
    logic [1:0] ndots;
    logic       has_char;
    logic [7:0] ch;
    logic       has_status;
    logic [2:0] status;
  } cmd_t;

endpackage

// File: hw/rtl/relative_path_normalizer.sv
// Relative path normaliser: top level joining front end, command queue
// and back end. Depends on rpn_pkg, rpn_front, rpn_cmdq and rpn_back.
//
// Input side is a queue write port: a byte is taken on a clock edge with
// push high and full low; in_last marks the final byte of a path.
// Result side is a queue read port: while empty is low the oldest result
// sits on out_char/is_status/status/out_last and is taken with pop.
// Each path yields its normalised bytes followed by one status item
// (is_status and out_last high); the bytes are good only on status 0.
// content_ref_mode is written through cfg_valid/cfg_data (cfg_ready is
// always high) and should only change while the block is idle.
// A byte's command passes the queue, then the output register. Most bytes give
// at most one result, so one byte per cycle is sustained while the reader
// pops; a byte that releases a separator, held dots and a status gives up to
// five results, one per cycle from the back end, and the command queue
// absorbs such bursts before full rises. When the reader stalls, results hold
// in the output register and the queue fills, then full holds off the writer.
// Synchronous reset clears the segment state, the queue and the output
// register and sets content_ref_mode to 0.
module relative_path_normalizer #(
  parameter int unsigned QUEUE_DEPTH = rpn_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_char,
  output logic       is_status,
  output logic [2:0] status,
  output logic       out_last,
  output logic       empty,
  input  logic       pop,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  rpn_pkg::cmd_t fe_cmd, q_cmd;
  logic          fe_push, q_full, q_empty, be_take, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  rpn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_char   (in_char),
    .in_last   (in_last),
    .accept    (accept),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_push  (fe_push),
    .cmd       (fe_cmd)
  );

  rpn_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (fe_push),
    .wr_data (fe_cmd),
    .full    (q_full),
    .rd      (be_take),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  rpn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (!q_empty),
    .cmd_take  (be_take),
    .out_char  (out_char),
    .is_status (is_status),
    .status    (status),
    .out_last  (out_last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: hw/rtl/rpn_front.sv
// Front end: accepts path bytes, tracks segment state and the prefix,
// and issues commands for output-giving and closing bytes. Depends on rpn_pkg.
module rpn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  input  logic              accept,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              cmd_push,
  output rpn_pkg::cmd_t     cmd
);

  logic       mode;
  logic [1:0] phase, phase_next;
  logic       started, started_next;
  logic       first_byte;
  logic       bad_seen, bad_next;
  logic       lead_seen, lead_next;
  logic       parent_seen, parent_next;
  logic [3:0] pcount, pcount_next;
  logic [7:0] pstore [rpn_pkg::PREFIX_DEPTH];
  logic [7:0] pview  [rpn_pkg::PREFIX_DEPTH];

  logic [7:0] c;
  logic       invalid;
  logic       open_seg;
  logic [1:0] open_dots;
  logic       emit_plain;
  logic       parent_fin;
  logic       dot_slash, dotdot_slash, content_exact, content_slash, pmatch7, pmatch8;
  logic       reject;
  logic [2:0] st;

  assign cfg_ready = 1'b1;
  assign c = (in_char == rpn_pkg::CH_BSL) ? rpn_pkg::CH_SLASH : in_char;

  assign invalid = (c < rpn_pkg::CH_LOW) || (c == rpn_pkg::CH_LT) ||
                   (c == rpn_pkg::CH_GT) || (c == rpn_pkg::CH_COLON) ||
                   (c == rpn_pkg::CH_QUOTE) || (c == rpn_pkg::CH_PIPE) ||
                   (c == rpn_pkg::CH_QMARK) || (c == rpn_pkg::CH_STAR);

  // Segment state machine
  always_comb begin
    phase_next  = phase;
    parent_next = parent_seen;
    open_seg    = 1'b0;
    open_dots   = 2'd0;
    emit_plain  = 1'b0;
    if (invalid) begin
      phase_next = phase;
    end else if (c == rpn_pkg::CH_SLASH) begin
      if (phase == rpn_pkg::PH_DOT2) parent_next = 1'b1;
      phase_next = rpn_pkg::PH_START;
    end else if (c == rpn_pkg::CH_DOT) begin
      unique case (phase)
        rpn_pkg::PH_START: phase_next = rpn_pkg::PH_DOT1;
        rpn_pkg::PH_DOT1:  phase_next = rpn_pkg::PH_DOT2;
        rpn_pkg::PH_DOT2: begin
          open_seg   = 1'b1;
          open_dots  = 2'd2;
          phase_next = rpn_pkg::PH_SEG;
        end
        default: emit_plain = 1'b1;
      endcase
    end else begin
      unique case (phase)
        rpn_pkg::PH_START: open_seg = 1'b1;
        rpn_pkg::PH_DOT1: begin
          open_seg  = 1'b1;
          open_dots = 2'd1;
        end
        rpn_pkg::PH_DOT2: begin
          open_seg  = 1'b1;
          open_dots = 2'd2;
        end
        default: emit_plain = 1'b1;
      endcase
      phase_next = rpn_pkg::PH_SEG;
    end
  end

  assign started_next = started | open_seg;
  assign bad_next     = bad_seen | invalid;
  assign lead_next    = lead_seen | (first_byte && (c == rpn_pkg::CH_SLASH));
  assign parent_fin   = parent_next | (phase_next == rpn_pkg::PH_DOT2);
  assign pcount_next  = (pcount < 4'(rpn_pkg::PREFIX_DEPTH)) ? pcount + 4'd1 : pcount;

  // Prefix as it stands including this byte
  always_comb begin
    for (int i = 0; i < rpn_pkg::PREFIX_DEPTH; i++) begin
      pview[i] = (pcount == 4'(i)) ? c : pstore[i];
    end
  end

  always_comb begin
    pmatch7 = 1'b1;
    pmatch8 = 1'b1;
    for (int i = 0; i < rpn_pkg::PREFIX_DEPTH; i++) begin
      if (pview[i] != rpn_pkg::CONTENT_SLASH[63-8*i -: 8]) begin
        pmatch8 = 1'b0;
        if (i < 7) pmatch7 = 1'b0;
      end
    end
  end

  assign dot_slash     = (pcount_next >= 4'd2) && (pview[0] == rpn_pkg::CH_DOT) &&
                         (pview[1] == rpn_pkg::CH_SLASH);
  assign dotdot_slash  = (pcount_next >= 4'd3) && (pview[0] == rpn_pkg::CH_DOT) &&
                         (pview[1] == rpn_pkg::CH_DOT) && (pview[2] == rpn_pkg::CH_SLASH);
  assign content_exact = (pcount_next == 4'd7) && pmatch7;
  assign content_slash = (pcount_next == 4'd8) && pmatch8;
  assign reject = mode && (dot_slash || dotdot_slash || content_exact || content_slash);

  always_comb begin
    priority if (reject)     st = rpn_pkg::ST_PREFIX;
    else if (bad_next)       st = rpn_pkg::ST_BADCHAR;
    else if (lead_next)      st = rpn_pkg::ST_LEADING;
    else if (parent_fin)     st = rpn_pkg::ST_PARENT;
    else if (!started_next)  st = rpn_pkg::ST_EMPTY;
    else                     st = rpn_pkg::ST_OK;
  end

  always_comb begin
    cmd.sep        = open_seg & started;
    cmd.ndots      = open_dots;
    cmd.has_char   = open_seg | emit_plain;
    cmd.ch         = c;
    cmd.has_status = in_last;
    cmd.status     = st;
  end

  assign cmd_push = accept && (open_seg || emit_plain || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pcount < 4'(rpn_pkg::PREFIX_DEPTH))) begin
      pstore[pcount[2:0]] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      phase       <= rpn_pkg::PH_START;
      started     <= 1'b0;
      first_byte  <= 1'b1;
      bad_seen    <= 1'b0;
      lead_seen   <= 1'b0;
      parent_seen <= 1'b0;
      pcount      <= 4'd0;
    end else if (accept) begin
      phase       <= phase_next;
      started     <= started_next;
      first_byte  <= 1'b0;
      bad_seen    <= bad_next;
      lead_seen   <= lead_next;
      parent_seen <= parent_next;
      pcount      <= pcount_next;
    end
  end

endmodule

// File: hw/rtl/rpn_cmdq.sv
// Short command queue between the front and back ends, held in flip-flops.
// Depends on rpn_pkg for the command type.
module rpn_cmdq #(
  parameter int unsigned DEPTH = rpn_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rpn_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd,
  output rpn_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rpn_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_rd) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// File: hw/rtl/rpn_back.sv
// Back end: expands each command into result items in an output register,
// one per cycle while it is free or popped. Depends on rpn_pkg.
module rpn_back (
  input  logic          clk,
  input  logic          rst,
  input  rpn_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_take,
  output logic [7:0]    out_char,
  output logic          is_status,
  output logic [2:0]    status,
  output logic          out_last,
  output logic          empty,
  input  logic          pop
);

  logic       out_valid;
  logic [2:0] step;
  logic [2:0] b1, b2, cnt;
  logic       load, final_item;
  logic [7:0] it_char;
  logic       it_stat;

  assign b1  = {2'b00, cmd.sep};
  assign b2  = b1 + {1'b0, cmd.ndots};
  assign cnt = b2 + {2'b00, cmd.has_char} + {2'b00, cmd.has_status};

  // Pick the item at the current step: separator, dots, byte, status
  always_comb begin
    it_stat = 1'b0;
    it_char = 8'h00;
    priority if (step < b1) begin
      it_char = rpn_pkg::CH_SLASH;
    end else if (step < b2) begin
      it_char = rpn_pkg::CH_DOT;
    end else if (cmd.has_char && (step == b2)) begin
      it_char = cmd.ch;
    end else begin
      it_stat = 1'b1;
    end
  end

  assign load       = cmd_valid && (!out_valid || pop);
  assign final_item = (step == cnt - 3'd1);
  assign cmd_take   = load && final_item;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= it_char;
      is_status <= it_stat;
      status    <= it_stat ? cmd.status : rpn_pkg::ST_OK;
      out_last  <= it_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) step <= final_item ? 3'd0 : step + 3'd1;
    end
  end

endmodule

// File: tb/tb_relative_path_normalizer.sv
// Testbench for relative_path_normalizer: drives paths byte by byte, tracks the
// expected normalised bytes and verdicts in a small class and checks every result.
// Depends on rpn_pkg and the relative_path_normalizer RTL.
module tb_relative_path_normalizer;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 55;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct {
    logic [7:0] ch;
    logic       is_st;
    logic [2:0] st;
    logic       last;
  } norm_item_t;

  class normaliser_tracker;
    bit          ref_mode;
    logic [1:0]  phase;
    bit          started, at_first, bad, lead, parent;
    logic [7:0]  head [rpn_pkg::PREFIX_DEPTH];
    int unsigned head_len;
    norm_item_t  awaited_items [$];
    int unsigned errors;

    function new();
      ref_mode = 0;
      errors = 0;
      clear_path();
    endfunction

    function void clear_path();
      phase = rpn_pkg::PH_START;
      started = 0;
      at_first = 1;
      bad = 0;
      lead = 0;
      parent = 0;
      head_len = 0;
    endfunction

    function void set_mode(bit m);
      ref_mode = m;
    endfunction

    function bit idle();
      return awaited_items.size() == 0;
    endfunction

    function void add_item(logic [7:0] ch, logic is_st, logic [2:0] st, logic last);
      norm_item_t it;
      it.ch = ch;
      it.is_st = is_st;
      it.st = st;
      it.last = last;
      awaited_items.insert(awaited_items.size(), it);
    endfunction

    // Release the separator, then any held dots, then the byte itself
    function void open_segment(int dots, logic [7:0] ch);
      if (started) add_item(rpn_pkg::CH_SLASH, 1'b0, rpn_pkg::ST_OK, 1'b0);
      repeat (dots) add_item(rpn_pkg::CH_DOT, 1'b0, rpn_pkg::ST_OK, 1'b0);
      add_item(ch, 1'b0, rpn_pkg::ST_OK, 1'b0);
      started = 1;
    endfunction

    function bit head_is(string s);
      if (head_len < s.len()) return 0;
      for (int i = 0; i < s.len(); i++)
        if (head[i] != s[i]) return 0;
      return 1;
    endfunction

    function void take_byte(logic [7:0] raw, logic last);
      logic [7:0] c;
      logic [2:0] verdict;
      c = (raw == rpn_pkg::CH_BSL) ? rpn_pkg::CH_SLASH : raw;
      if (head_len < rpn_pkg::PREFIX_DEPTH) begin
        head[head_len] = c;
        head_len++;
      end
      if (at_first && c == rpn_pkg::CH_SLASH) lead = 1;
      at_first = 0;

      if (c < rpn_pkg::CH_LOW ||
          c inside {rpn_pkg::CH_LT, rpn_pkg::CH_GT, rpn_pkg::CH_COLON,
                    rpn_pkg::CH_QUOTE, rpn_pkg::CH_PIPE, rpn_pkg::CH_QMARK,
                    rpn_pkg::CH_STAR}) begin
        bad = 1;
      end else if (c == rpn_pkg::CH_SLASH) begin
        if (phase == rpn_pkg::PH_DOT2) parent = 1;
        phase = rpn_pkg::PH_START;
      end else if (c == rpn_pkg::CH_DOT) begin
        case (phase)
          rpn_pkg::PH_START: phase = rpn_pkg::PH_DOT1;
          rpn_pkg::PH_DOT1:  phase = rpn_pkg::PH_DOT2;
          rpn_pkg::PH_DOT2: begin
            open_segment(2, c);
            phase = rpn_pkg::PH_SEG;
          end
          default: add_item(c, 1'b0, rpn_pkg::ST_OK, 1'b0);
        endcase
      end else begin
        case (phase)
          rpn_pkg::PH_START: open_segment(0, c);
          rpn_pkg::PH_DOT1:  open_segment(1, c);
          rpn_pkg::PH_DOT2:  open_segment(2, c);
          default:           add_item(c, 1'b0, rpn_pkg::ST_OK, 1'b0);
        endcase
        phase = rpn_pkg::PH_SEG;
      end

      if (last) begin
        // Two dots held at the end make a parent segment; one is simply dropped
        if (phase == rpn_pkg::PH_DOT2) parent = 1;
        if (ref_mode && (head_is("./") || head_is("../") ||
                         (head_len == 7 && head_is("content")) || head_is("content/")))
          verdict = rpn_pkg::ST_PREFIX;
        else if (bad)      verdict = rpn_pkg::ST_BADCHAR;
        else if (lead)     verdict = rpn_pkg::ST_LEADING;
        else if (parent)   verdict = rpn_pkg::ST_PARENT;
        else if (!started) verdict = rpn_pkg::ST_EMPTY;
        else               verdict = rpn_pkg::ST_OK;
        add_item(8'h00, 1'b1, verdict, 1'b1);
        clear_path();
      end
    endfunction

    function void match_result(logic [7:0] ch, logic is_st, logic [2:0] st, logic last);
      norm_item_t want;
      if (awaited_items.size() == 0) begin
        $display("%0t: result with nothing expected: out_char %h is_status %b status %0d",
                 $time, ch, is_st, st);
        errors++;
        return;
      end
      want = awaited_items.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char expected %h got %h", $time, want.ch, ch);
        errors++;
      end
      if (is_st !== want.is_st) begin
        $display("%0t: is_status expected %b got %b", $time, want.is_st, is_st);
        errors++;
      end
      if (st !== want.st) begin
        $display("%0t: status expected %0d got %0d", $time, want.st, st);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %b got %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] out_char;
  logic       is_status;
  logic [2:0] status;
  logic       out_last;
  logic       empty;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  normaliser_tracker tracker = new();
  logic [7:0]  path_q [$];
  int unsigned cycles = 0;
  bit          tx_steady = 0;
  bit          rx_steady = 0;
  bit          hold_req = 0;
  bit          hold_done = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  relative_path_normalizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_char   (in_char),
    .in_last   (in_last),
    .push      (push),
    .full      (full),
    .out_char  (out_char),
    .is_status (is_status),
    .status    (status),
    .out_last  (out_last),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Result side: check each taken result, then choose the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (cycles % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (pop && !empty) begin
        tracker.match_result(out_char, is_status, status, out_last);
        stall_left = pick_gap(rx_steady);
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] ch, logic last);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_char <= ch;
    in_last <= last;
    do @(posedge clk); while (full);
    tracker.take_byte(ch, last);
  endtask

  function automatic void add_byte(logic [7:0] b);
    path_q.insert(path_q.size(), b);
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++)
      send_byte(path_q[i], i == path_q.size() - 1);
    path_q.delete();
  endtask

  // Drop the request and wait until every expected result has come back
  task automatic settle();
    push <= 1'b0;
    while (!tracker.idle()) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_mode(m);
  endtask

  function automatic logic [7:0] pick_sep();
    return ($urandom_range(0, 1) == 0) ? rpn_pkg::CH_SLASH : rpn_pkg::CH_BSL;
  endfunction

  initial begin
    int unsigned sent;
    int          nseg, kind, r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed paths under content-reference mode
    write_mode(1'b1);
    append_text("content");
    send_path();
    append_text("./a");
    send_path();
    append_text("/a");
    send_path();
    append_text("a\\\\.//b/");
    send_path();
    append_text("x/..");
    send_path();
    append_text(".");
    send_path();
    append_text("a|");
    send_path();
    append_text("...");
    send_path();
    add_byte(8'hFF);
    send_path();
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph % 2 == 1);
      // Stall the reader for a long stretch while paths keep coming
      if (ph == 1) hold_req = 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 9) == 0) add_byte(pick_sep());
          nseg = $urandom_range(1, 4);
          for (int s = 0; s < nseg; s++) begin
            if (s > 0) repeat ($urandom_range(1, 2)) add_byte(pick_sep());
            kind = $urandom_range(0, 9);
            if (kind == 0) append_text(".");
            else if (kind == 1) append_text("..");
            else if (kind == 2) append_text("...");
            else if (kind == 3 && s == 0) append_text("content");
            else begin
              repeat ($urandom_range(1, 4)) begin
                r = $urandom_range(0, 9);
                if (r < 6)      add_byte(8'(8'h61 + $urandom_range(0, 25)));
                else if (r < 8) add_byte(8'(8'h30 + $urandom_range(0, 9)));
                else            add_byte(8'($urandom_range(8'h80, 8'hFF)));
              end
            end
            if ($urandom_range(0, 11) == 0) begin
              case ($urandom_range(0, 7))
                0: add_byte(rpn_pkg::CH_LT);
                1: add_byte(rpn_pkg::CH_GT);
                2: add_byte(rpn_pkg::CH_COLON);
                3: add_byte(rpn_pkg::CH_QUOTE);
                4: add_byte(rpn_pkg::CH_PIPE);
                5: add_byte(rpn_pkg::CH_QMARK);
                6: add_byte(rpn_pkg::CH_STAR);
                default: add_byte(8'($urandom_range(0, 31)));
              endcase
            end
          end
          if ($urandom_range(0, 6) == 0) add_byte(pick_sep());
        end
        sent += path_q.size();
        send_path();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.idle())
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
